// ===== rtl/rbr_pkg.sv =====
// ============================================================================
// rbr_pkg: shared definitions for the ring bit reservoir reader
// Sizes of the byte ring and the bit reader, operation codes and the
// control bundle that steers the digit shifter.
// ============================================================================
package rbr_pkg;

    // Byte ring.
    localparam int RingDepth  = 4096;
    localparam int AddrW      = $clog2(RingDepth);
    localparam int ByteW      = 8;
    localparam int PutWidth   = 8;

    // Bit reader.
    localparam int MaxGetBits = 32;
    localparam int RemW       = $clog2(MaxGetBits + 1);
    localparam int AccW       = MaxGetBits;
    localparam int LeftW      = $clog2(ByteW + 1);

    // Field and pointer widths.
    localparam int CountW     = 12;
    localparam int PtrW       = 32;
    localparam int ValueW     = 32;

    typedef enum logic [1:0] {
        OP_PUT          = 2'd0,
        OP_GET          = 2'd1,
        OP_REWIND_BITS  = 2'd2,
        OP_REWIND_BYTES = 2'd3
    } op_t;

    // One step of the digit shifter: the byte in rdata holds avail unread
    // bits, and remaining bits of the get are still wanted.
    typedef struct packed {
        logic             clear;
        logic             take;
        logic             byte_ok;
        logic [LeftW-1:0] avail;
        logic [RemW-1:0]  remaining;
    } digit_ctl_t;

endpackage

// ===== rtl/rbr_ram.sv =====
// ============================================================================
// rbr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module rbr_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rbr_digit_shifter.sv =====
// ============================================================================
// rbr_digit_shifter: byte-digit extractor and result shift register
// Takes up to one byte's worth of unread bits per cycle when take is set,
// MSB first, and shifts them into the right-aligned result accumulator.
// ============================================================================
module rbr_digit_shifter (
    input  logic                      clk,
    input  rbr_pkg::digit_ctl_t       ctl,
    input  logic [rbr_pkg::ByteW-1:0] rdata,
    output logic [rbr_pkg::LeftW-1:0] take_bits,
    output logic [rbr_pkg::AccW-1:0]  acc_next_out
);
    import rbr_pkg::*;

    logic [AccW-1:0]  acc_reg;
    logic [AccW-1:0]  acc_next;
    logic [ByteW-1:0] byte_w;
    logic [ByteW:0]   mask_w;
    logic [ByteW-1:0] masked_w;
    logic [ByteW-1:0] chunk_w;

    always_comb
    begin
        // The number of bits taken is the smaller of what the byte still
        // holds and what the transaction still wants.
        if ({{LeftW{1'b0}}, ctl.remaining} < {{RemW{1'b0}}, ctl.avail})
        begin
            take_bits = ctl.remaining[LeftW-1:0];
        end
        else
        begin
            take_bits = ctl.avail;
        end

        // A byte that has not been written yet reads as zero.
        byte_w   = ctl.byte_ok ? rdata : '0;
        mask_w   = ({{ByteW{1'b0}}, 1'b1} << ctl.avail) - {{ByteW{1'b0}}, 1'b1};
        masked_w = byte_w & mask_w[ByteW-1:0];
        chunk_w  = masked_w >> (ctl.avail - take_bits);

        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.take)
        begin
            acc_next = (acc_reg << take_bits) | AccW'(chunk_w);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_next_out = acc_next;

endmodule

// ===== rtl/ring_bit_reservoir_reader_unit.sv =====
// ============================================================================
// ring_bit_reservoir_reader_unit: byte ring bit reservoir with bit reader
// Appends bytes to a ring, reads them back MSB first in fields of up to
// 32 bits, and rewinds the read point by bits or bytes.
// ============================================================================
//
// A transaction is accepted on a clock edge with start high and busy low,
// and every transaction produces exactly one result, shown for a single
// cycle with done high; the receiver cannot stall it, so it must take the
// result in that cycle. Put, both rewinds and a get of zero bits finish at
// the accepting edge: done rises in the next cycle and busy never rises, so
// such transactions may be issued every cycle. A get raises busy while it
// passes through ST_ADDR and then ST_DATA, which handles each ring byte
// that the read touches (at most five for a 32-bit get), and done follows
// in the first cycle with busy low; a new transaction may be accepted in
// that same cycle. The steps are set by the ring RAM's single registered
// read port: ST_ADDR sets up the first address, then one byte is consumed
// per cycle while the next byte is fetched ahead. A get that reaches a
// byte not yet written reads zeros for those bits and reports underrun,
// but still advances the read point. The ring contents are not cleared
// after reset; only bytes already written are ever read as data. Put
// widths other than eight are ignored apart from the result, and
// overwriting unread bytes is not detected.
//
module ring_bit_reservoir_reader_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 op,
    input  logic [rbr_pkg::ByteW-1:0]  data_byte,
    input  logic [rbr_pkg::CountW-1:0] count,
    output logic                       done,
    output logic [rbr_pkg::ValueW-1:0] value,
    output logic [rbr_pkg::PtrW-1:0]   bit_position,
    output logic                       underrun
);
    import rbr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA
    } state_t;

    // Sequencer state and pointers.
    state_t            state_reg,     state_next;
    logic [PtrW-1:0]   wr_count_reg,  wr_count_next;
    logic [PtrW-1:0]   rd_idx_reg,    rd_idx_next;
    logic [LeftW-1:0]  left_reg,      left_next;
    logic [PtrW-1:0]   total_reg,     total_next;
    logic [RemW-1:0]   rem_reg,       rem_next;
    logic              under_acc_reg, under_acc_next;

    // Registered result.
    logic              done_reg,      done_next;
    logic [ValueW-1:0] value_reg,     value_next;
    logic              under_out_reg, under_out_next;

    op_t               cmd_op;
    logic              accept;
    logic              need_adv;
    logic [PtrW-1:0]   eff_idx;
    logic [LeftW-1:0]  eff_left;
    logic              byte_ok;
    logic [RemW-1:0]   get_n;
    logic [CountW:0]   rewind_sum;
    logic [PtrW-1:0]   rd_addr_idx;
    logic              ram_we;
    logic [ByteW-1:0]  ram_rdata;
    digit_ctl_t        digit_ctl;
    logic [LeftW-1:0]  take_bits;
    logic [AccW-1:0]   acc_next;

    assign cmd_op = op_t'(op);
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // When the current byte is used up, the read moves on to the next one
    // only once more bits are actually wanted; these give that next byte.
    assign need_adv = (left_reg == '0);
    assign eff_idx  = rd_idx_reg + PtrW'(need_adv);
    assign eff_left = need_adv ? LeftW'(ByteW) : left_reg;
    assign byte_ok  = (eff_idx < wr_count_reg);

    // Gets longer than the reader's limit are saturated.
    assign get_n = (count > CountW'(MaxGetBits)) ? RemW'(MaxGetBits) : count[RemW-1:0];

    // Rewinding by bits counts from the end of the current byte, adding its unread bits.
    assign rewind_sum = {1'b0, count} + {{(CountW + 1 - LeftW){1'b0}}, left_reg};

    // While consuming a byte, the byte after it is fetched ahead so that
    // one byte is handled per cycle.
    assign rd_addr_idx = eff_idx + PtrW'(state_reg == ST_DATA);

    assign ram_we = accept && (cmd_op == OP_PUT) && (count == CountW'(PutWidth));

    rbr_ram #(
        .Width (ByteW),
        .Depth (RingDepth)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_count_reg[AddrW-1:0]),
        .wdata (data_byte),
        .raddr (rd_addr_idx[AddrW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        digit_ctl.clear     = accept && (cmd_op == OP_GET);
        digit_ctl.take      = (state_reg == ST_DATA);
        digit_ctl.byte_ok   = byte_ok;
        digit_ctl.avail     = eff_left;
        digit_ctl.remaining = rem_reg;
    end

    rbr_digit_shifter u_shifter (
        .clk          (clk),
        .ctl          (digit_ctl),
        .rdata        (ram_rdata),
        .take_bits    (take_bits),
        .acc_next_out (acc_next)
    );

    always_comb
    begin
        state_next     = state_reg;
        wr_count_next  = wr_count_reg;
        rd_idx_next    = rd_idx_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        under_acc_next = under_acc_reg;
        done_next      = 1'b0;
        value_next     = value_reg;
        under_out_next = under_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next     = '0;
                    under_out_next = 1'b0;
                    case (cmd_op)
                        OP_PUT:
                        begin
                            if (count == CountW'(PutWidth))
                            begin
                                wr_count_next = wr_count_reg + PtrW'(1);
                            end
                            done_next = 1'b1;
                        end
                        OP_GET:
                        begin
                            // The position moves by the whole get at once.
                            total_next     = total_reg + PtrW'(get_n);
                            rem_next       = get_n;
                            under_acc_next = 1'b0;
                            if (get_n == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ADDR;
                            end
                        end
                        OP_REWIND_BITS:
                        begin
                            total_next  = total_reg - PtrW'(count);
                            rd_idx_next = rd_idx_reg - PtrW'(rewind_sum[CountW:3]);
                            left_next   = LeftW'(rewind_sum[2:0]);
                            done_next   = 1'b1;
                        end
                        OP_REWIND_BYTES:
                        begin
                            total_next  = total_reg - PtrW'({count, 3'b000});
                            rd_idx_next = rd_idx_reg - PtrW'(count);
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADDR:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                rd_idx_next    = eff_idx;
                left_next      = eff_left - take_bits;
                rem_next       = rem_reg - RemW'(take_bits);
                under_acc_next = under_acc_reg || !byte_ok;
                if (rem_reg == RemW'(take_bits))
                begin
                    done_next      = 1'b1;
                    value_next     = ValueW'(acc_next);
                    under_out_next = under_acc_reg || !byte_ok;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_count_reg  <= '0;
            rd_idx_reg    <= '0;
            left_reg      <= LeftW'(ByteW);
            total_reg     <= '0;
            rem_reg       <= '0;
            under_acc_reg <= 1'b0;
            done_reg      <= 1'b0;
            value_reg     <= '0;
            under_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_count_reg  <= wr_count_next;
            rd_idx_reg    <= rd_idx_next;
            left_reg      <= left_next;
            total_reg     <= total_next;
            rem_reg       <= rem_next;
            under_acc_reg <= under_acc_next;
            done_reg      <= done_next;
            value_reg     <= value_next;
            under_out_reg <= under_out_next;
        end
    end

    assign done         = done_reg;
    assign value        = value_reg;
    assign bit_position = total_reg;
    assign underrun     = under_out_reg;

`ifndef SYNTHESIS
    // A result is only ever presented once the sequencer has gone idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // The bit count of the current byte never exceeds a byte.
    assert property (@(posedge clk) disable iff (!rst_n) left_reg <= LeftW'(ByteW))
        else $error("bits left in byte out of range");

    // Consuming bytes only happens while bits are still owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (rem_reg != '0))
        else $error("byte step with nothing left to read");

    // The address setup cycle is always followed by data consumption.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |=> (state_reg == ST_DATA))
        else $error("address cycle not followed by data cycle");
`endif

endmodule
